// File: rtl/bph_pkg.sv
// Shared constants, types and state encoding for the bounded-probe hash table.
`timescale 1ns / 1ps

package bph_pkg;

  localparam int KEY_W        = 32;
  localparam int DATA_W       = 32;
  localparam int COUNT_W      = 9;
  localparam int ENTRY_W      = KEY_W + DATA_W;
  localparam int KEY_BYTES    = KEY_W / 8;

  localparam int TABLE_SLOTS_DEF  = 256;
  localparam int WINDOW_SLOTS_DEF = 16;

  localparam logic [KEY_W-1:0] EMPTY_KEY = '0;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_LOOKUP = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HOME,
    ST_PROBE,
    ST_WRITE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic rd;
    logic wr;
  } mem_cmd_t;

endpackage

// File: rtl/bph_if.sv
// Valid/ready channel interfaces for requests and responses.
`timescale 1ns / 1ps

interface bph_req_if;
  logic                             valid;
  logic                             ready;
  logic                             mode;
  logic [bph_pkg::KEY_W-1:0]        key;
  logic signed [bph_pkg::DATA_W-1:0] write_data;

  modport source (output valid, output mode, output key, output write_data, input ready);
  modport sink   (input valid, input mode, input key, input write_data, output ready);
endinterface

interface bph_rsp_if;
  logic                              valid;
  logic                              ready;
  logic                              status;
  logic signed [bph_pkg::DATA_W-1:0] read_data;
  logic [bph_pkg::COUNT_W-1:0]       stored_count;

  modport source (output valid, output status, output read_data, output stored_count,
                  input ready);
  modport sink   (input valid, input status, input read_data, input stored_count,
                  output ready);
endinterface

// File: rtl/bph_mem.sv
// Single-port slot memory, key in the upper half, data in the lower half.
`timescale 1ns / 1ps

module bph_mem #(
  parameter int DEPTH  = bph_pkg::TABLE_SLOTS_DEF,
  parameter int ADDR_W = $clog2(DEPTH),
  parameter int WIDTH  = bph_pkg::ENTRY_W
) (
  input  logic               clk,
  input  bph_pkg::mem_cmd_t  cmd,
  input  logic [ADDR_W-1:0]  addr,
  input  logic [WIDTH-1:0]   wdata,
  output logic [WIDTH-1:0]   rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[addr] <= wdata;
    end
    if (cmd.rd) begin
      rdata <= mem[addr];
    end
  end

endmodule

// File: rtl/bph_ctrl.sv
// Sequencer: clearing pass, home-slot select, probe loop, write-back, result register.
`timescale 1ns / 1ps

module bph_ctrl #(
  parameter int TABLE_SLOTS  = bph_pkg::TABLE_SLOTS_DEF,
  parameter int WINDOW_SLOTS = bph_pkg::WINDOW_SLOTS_DEF,
  parameter int IDX_W        = $clog2(TABLE_SLOTS)
) (
  input  logic                        clk,
  input  logic                        rst,
  bph_req_if.sink                     req,
  bph_rsp_if.source                   rsp,
  output bph_pkg::mem_cmd_t           mem_cmd,
  output logic [IDX_W-1:0]            mem_addr,
  output logic [bph_pkg::ENTRY_W-1:0] mem_wdata,
  input  logic [bph_pkg::ENTRY_W-1:0] mem_rdata
);

  localparam int WIN_W   = $clog2(WINDOW_SLOTS + 1);
  localparam int CNT_W   = $clog2(TABLE_SLOTS + 1);

  localparam logic [IDX_W-1:0]  LAST_SLOT = IDX_W'(TABLE_SLOTS - 1);
  localparam logic [WIN_W-1:0]  WIN_LAST  = WIN_W'(WINDOW_SLOTS - 1);
  localparam logic [WIN_W-1:0]  WIN_FULL  = WIN_W'(WINDOW_SLOTS);
  localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(TABLE_SLOTS);

  bph_pkg::state_t state, state_next;

  logic                              op_mode;
  logic [bph_pkg::KEY_W-1:0]         op_key;
  logic [bph_pkg::DATA_W-1:0]        op_data;
  logic [IDX_W-1:0]                  slot;
  logic [IDX_W-1:0]                  rd_slot;
  logic [IDX_W-1:0]                  hit_slot;
  logic [IDX_W-1:0]                  clr_addr;
  logic [WIN_W-1:0]                  issue_cnt;
  logic [WIN_W-1:0]                  chk_cnt;
  logic                              rd_valid;
  logic                              res_status;
  logic signed [bph_pkg::DATA_W-1:0] res_data;
  logic [CNT_W-1:0]                  count;
  logic                              out_valid;
  logic                              out_status;
  logic signed [bph_pkg::DATA_W-1:0] out_data;
  logic [bph_pkg::COUNT_W-1:0]       out_count;

  logic [bph_pkg::KEY_W-1:0]  key_rd;
  logic [bph_pkg::DATA_W-1:0] val_rd;
  logic                       probe_hit;
  logic                       probe_last;
  logic                       issue;
  logic                       out_free;

  assign key_rd     = mem_rdata[bph_pkg::ENTRY_W-1 -: bph_pkg::KEY_W];
  assign val_rd     = mem_rdata[bph_pkg::DATA_W-1:0];
  assign probe_hit  = rd_valid && ((op_mode == bph_pkg::MODE_INSERT) ?
                                   (key_rd == bph_pkg::EMPTY_KEY) : (key_rd == op_key));
  assign probe_last = rd_valid && (chk_cnt == WIN_LAST);
  assign issue      = (state == bph_pkg::ST_PROBE) && (issue_cnt != WIN_FULL) && !probe_hit;
  assign out_free   = !out_valid || rsp.ready;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      bph_pkg::ST_CLEAR: begin
        if (clr_addr == LAST_SLOT) state_next = bph_pkg::ST_IDLE;
      end
      bph_pkg::ST_IDLE: begin
        if (req.valid) state_next = bph_pkg::ST_HOME;
      end
      bph_pkg::ST_HOME: begin
        state_next = (op_key == bph_pkg::EMPTY_KEY) ? bph_pkg::ST_FINISH : bph_pkg::ST_PROBE;
      end
      bph_pkg::ST_PROBE: begin
        if (probe_hit) begin
          state_next = (op_mode == bph_pkg::MODE_INSERT) ? bph_pkg::ST_WRITE
                                                         : bph_pkg::ST_FINISH;
        end else if (probe_last) begin
          state_next = bph_pkg::ST_FINISH;
        end
      end
      bph_pkg::ST_WRITE: begin
        state_next = bph_pkg::ST_FINISH;
      end
      bph_pkg::ST_FINISH: begin
        if (out_free) state_next = bph_pkg::ST_IDLE;
      end
      default: state_next = bph_pkg::ST_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    req.ready  = (state == bph_pkg::ST_IDLE);
    mem_cmd.rd = issue;
    mem_cmd.wr = (state == bph_pkg::ST_CLEAR) || (state == bph_pkg::ST_WRITE);
    case (state)
      bph_pkg::ST_CLEAR: begin
        mem_addr  = clr_addr;
        mem_wdata = '0;
      end
      bph_pkg::ST_WRITE: begin
        mem_addr  = hit_slot;
        mem_wdata = {op_key, op_data};
      end
      default: begin
        mem_addr  = slot;
        mem_wdata = {op_key, op_data};
      end
    endcase
  end

  assign rsp.valid        = out_valid;
  assign rsp.status       = out_status;
  assign rsp.read_data    = out_data;
  assign rsp.stored_count = out_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bph_pkg::ST_CLEAR;
      clr_addr  <= '0;
      rd_valid  <= 1'b0;
      out_valid <= 1'b0;
      count     <= '0;
    end else begin
      state    <= state_next;
      rd_valid <= issue;

      if (state == bph_pkg::ST_CLEAR) clr_addr <= clr_addr + 1'b1;

      if (state == bph_pkg::ST_WRITE) count <= count + 1'b1;

      if (state == bph_pkg::ST_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end

    // payload
    if (state == bph_pkg::ST_IDLE && req.valid) begin
      op_mode  <= req.mode;
      op_key   <= req.key;
      op_data  <= req.write_data;
    end

    if (state == bph_pkg::ST_HOME) begin
      // table size is a power of two: the home slot is the low key bits
      slot       <= op_key[IDX_W-1:0];
      issue_cnt  <= '0;
      chk_cnt    <= '0;
      res_status <= bph_pkg::STATUS_FAIL;
      res_data   <= '0;
    end

    if (issue) begin
      slot      <= (slot == LAST_SLOT) ? '0 : slot + 1'b1;
      issue_cnt <= issue_cnt + 1'b1;
      rd_slot   <= slot;
    end

    if (state == bph_pkg::ST_PROBE && rd_valid) begin
      chk_cnt <= chk_cnt + 1'b1;
      if (probe_hit) begin
        hit_slot <= rd_slot;
        if (op_mode == bph_pkg::MODE_LOOKUP) begin
          res_status <= bph_pkg::STATUS_OK;
          res_data   <= $signed(val_rd);
        end
      end
    end

    if (state == bph_pkg::ST_WRITE) res_status <= bph_pkg::STATUS_OK;

    if (state == bph_pkg::ST_FINISH && out_free) begin
      out_status <= res_status;
      out_data   <= res_data;
      out_count  <= bph_pkg::COUNT_W'(count);
    end
  end

  // checks
  a_rd_wr_excl: assert property (@(posedge clk) disable iff (rst)
    !(mem_cmd.rd && mem_cmd.wr))
    else $error("slot memory read and written in the same cycle");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    state == bph_pkg::ST_WRITE |=> count == $past(count) + 1'b1)
    else $error("entry count did not advance on write-back");

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_MAX)
    else $error("entry count above table size");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status == bph_pkg::STATUS_FAIL |-> out_data == '0)
    else $error("failed transaction carries nonzero data");

  a_rd_in_probe: assert property (@(posedge clk) disable iff (rst)
    rd_valid |-> state == bph_pkg::ST_PROBE)
    else $error("probe read returned outside the probe loop");

endmodule

// File: rtl/bounded_probe_hash_table_core.sv
// Top level of the bounded linear-probe hash table.
`timescale 1ns / 1ps
//
//  channel | dir | handshake        | payload
//  --------+-----+------------------+-------------------------------------------
//  req     | in  | req.valid/ready  | mode, key, write_data
//  rsp     | out | rsp.valid/ready  | status, read_data, stored_count
//
//  One transaction at a time. Accept step, then the home slot is taken (low key
//  bits, TABLE_SLOTS being a power of two), then k slots are checked, at most
//  WINDOW_SLOTS (16 by default), through the single memory port (reads pipelined
//  one per cycle), then a write-back on a successful insert, then the response
//  register is loaded; a zero key goes from the home step straight to the response.
//  After rst the table is swept to empty, one slot per cycle; req.ready stays low
//  until the sweep is done.
//  The response register lets a new request be taken while the previous response
//  waits; the sequencer holds in its last step while rsp stalls.

module bounded_probe_hash_table_core #(
  parameter int TABLE_SLOTS  = bph_pkg::TABLE_SLOTS_DEF,
  parameter int WINDOW_SLOTS = bph_pkg::WINDOW_SLOTS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  bph_req_if.sink    req,
  bph_rsp_if.source  rsp
);

  localparam int IDX_W = $clog2(TABLE_SLOTS);

  // controller <-> slot memory
  bph_pkg::mem_cmd_t           mem_cmd;
  logic [IDX_W-1:0]            mem_addr;
  logic [bph_pkg::ENTRY_W-1:0] mem_wdata;
  logic [bph_pkg::ENTRY_W-1:0] mem_rdata;

  // sequencer: sweep, home slot, probing, write-back, response register
  bph_ctrl #(
    .TABLE_SLOTS  (TABLE_SLOTS),
    .WINDOW_SLOTS (WINDOW_SLOTS),
    .IDX_W        (IDX_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .mem_cmd   (mem_cmd),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata)
  );

  // key/data slots, one port, registered read
  bph_mem #(
    .DEPTH  (TABLE_SLOTS),
    .ADDR_W (IDX_W),
    .WIDTH  (bph_pkg::ENTRY_W)
  ) u_mem (
    .clk   (clk),
    .cmd   (mem_cmd),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

endmodule
